FILE: src/register_fletcher_checksum_defines.svh
// ----------------------------------------------------------------------------
// Register Fletcher checksum: assertion macros
// Assertion shorthands for the checksum block's checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_FLETCHER_CHECKSUM_DEFINES_SVH
`define REGISTER_FLETCHER_CHECKSUM_DEFINES_SVH

// same-cycle implication
`define RFC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RFC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rfc_pkg.sv
// ----------------------------------------------------------------------------
// Register Fletcher checksum package
// Widths, item type and the modulo 2^32-1 reduction helpers.
// ----------------------------------------------------------------------------
package rfc_pkg;

   localparam int WORD_W = 64;
   localparam int SUM_W  = 32;

   localparam logic [SUM_W:0] MOD_33  = {1'b0, {SUM_W{1'b1}}};
   localparam logic [SUM_W:0] MOD2_33 = {{SUM_W{1'b1}}, 1'b0};

   typedef struct packed {
      logic              last;
      logic [WORD_W-1:0] word;
   } item_type;

   // reduce a value in [0, 2*MOD] to [0, MOD)
   function automatic logic [SUM_W-1:0] reduce33(input logic [SUM_W:0] t);
      logic [SUM_W:0] d;
      d = t - MOD_33;
      if (t == MOD2_33)
         return '0;
      else if (t >= MOD_33)
         return d[SUM_W-1:0];
      else
         return t[SUM_W-1:0];
   endfunction

   // 64-bit value modulo 2^32-1: end-around fold of the two halves
   function automatic logic [SUM_W-1:0] fold64(input logic [WORD_W-1:0] s);
      logic [SUM_W:0] t;
      t = {1'b0, s[WORD_W-1:SUM_W]} + {1'b0, s[SUM_W-1:0]};
      return reduce33(t);
   endfunction

   // (a + b) modulo 2^32-1, both operands already reduced
   function automatic logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return reduce33(t);
   endfunction

endpackage

FILE: src/register_fletcher_checksum.sv
// ----------------------------------------------------------------------------
// Register Fletcher checksum
// Fletcher-64 style checksum (modulus 2^32-1) over a stream of register words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tlast
//  req_    | in  | [63:0] word            | last word of the block
//  rsp_    | out | [63:0] checksum        | -
//
//  One beat per cycle unless a final word waits behind an untaken result;
//  words wait in the input register, the final checksum in the result one.
//  The feedback path is the 64-bit add into the low sum, its fold modulo
//  2^32-1, and the high-sum add that follows it.
//  reset (synchronous) clears both sums and empties both registers.
//  req_tready drops only while a final word waits behind an untaken result.
// ----------------------------------------------------------------------------
module register_fletcher_checksum
   import rfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,    // [63:0] word
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata     // [63:0] checksum
);

   item_type          in_item, cur_item;
   logic              in_vld, fire, req_beat, rsp_beat;
   logic              out_vld;
   logic [WORD_W-1:0] checksum;

   assign in_item.word = req_tdata;
   assign in_item.last = req_tlast;

   // A beat moves on unless it is final and the result slot is still full.
   assign rsp_beat   = out_vld & rsp_tready;
   assign fire       = in_vld & (~cur_item.last | ~out_vld | rsp_tready);
   assign req_tready = ~in_vld | fire;
   assign req_beat   = req_tvalid & req_tready;

   rfc_in_reg u_in (
      .clock   (clock),
      .reset   (reset),
      .load    (req_beat),
      .item_in (in_item),
      .consume (fire),
      .vld     (in_vld),
      .item    (cur_item)
   );

   rfc_sum_unit u_sum (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (cur_item),
      .checksum (checksum)
   );

   rfc_out_reg u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (fire & cur_item.last),
      .data_in (checksum),
      .take    (rsp_beat),
      .vld     (out_vld),
      .data    (rsp_tdata)
   );

   assign rsp_tvalid = out_vld;

endmodule

FILE: src/rfc_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted beat until the sum unit consumes it.
// ----------------------------------------------------------------------------
module rfc_in_reg
   import rfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  item_type item_in,
   input  logic     consume,
   output logic     vld,
   output item_type item
);

   logic     vld_ff, vld_in;
   item_type item_ff;

   always_comb begin
      vld_in = vld_ff;
      if (consume) vld_in = 1'b0;
      if (load) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) item_ff <= item_in;
   end

   assign vld  = vld_ff;
   assign item = item_ff;

endmodule

FILE: src/rfc_sum_unit.sv
// ----------------------------------------------------------------------------
// Fletcher sum unit
// Running sums modulo 2^32-1; forms the checksum on the final beat.
// ----------------------------------------------------------------------------
module rfc_sum_unit
   import rfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  item_type          item,
   output logic [WORD_W-1:0] checksum
);

   logic [SUM_W-1:0]  low_ff, low_in, high_ff, high_in;
   logic [SUM_W-1:0]  low_nx, high_nx;
   logic [WORD_W-1:0] wide_sum;

   always_comb begin
      wide_sum = {{(WORD_W-SUM_W){1'b0}}, low_ff} + item.word;   // wraps at 64 bits
      low_nx   = low_ff;
      high_nx  = high_ff;
      if (item.word != '0) begin
         low_nx  = fold64(wide_sum);
         high_nx = add_mod(high_ff, low_nx);
      end
      checksum = {high_nx, low_nx};
      low_in   = low_ff;
      high_in  = high_ff;
      if (fire) begin
         low_in  = item.last ? '0 : low_nx;
         high_in = item.last ? '0 : high_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

FILE: src/rfc_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one checksum beat until the sink takes it.
// ----------------------------------------------------------------------------
module rfc_out_reg
   import rfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [WORD_W-1:0] data_in,
   input  logic              take,
   output logic              vld,
   output logic [WORD_W-1:0] data
);

   logic              vld_ff, vld_in;
   logic [WORD_W-1:0] data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (take) vld_in = 1'b0;
      if (load) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   assign vld  = vld_ff;
   assign data = data_ff;

endmodule

FILE: src/rfc_checker.sv
// ----------------------------------------------------------------------------
// Register Fletcher checksum checker
// Port-level properties of the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_fletcher_checksum_defines.svh"

module rfc_checker
   import rfc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [WORD_W-1:0] rsp_tdata
);

   logic last_beat;
   logic last_beat_d1_ff, last_beat_d2_ff;

   assign last_beat = req_tvalid & req_tready & req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_beat_d1_ff <= 1'b0;
         last_beat_d2_ff <= 1'b0;
      end else begin
         last_beat_d1_ff <= last_beat;
         last_beat_d2_ff <= last_beat_d1_ff;
      end
   end

   `RFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `RFC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")
   `RFC_ASSERT_NOW(a_rise_after_last, clock, reset, $rose(rsp_tvalid), last_beat_d2_ff, "result without final beat")
   `RFC_ASSERT_NOW(a_stall_cause, clock, reset, req_tvalid && !req_tready, rsp_tvalid, "input stalled with no result waiting")

endmodule

bind register_fletcher_checksum rfc_checker u_rfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
